[design/llc_voltage_compensator_top_defines.svh]
// Assertion helpers used by the top-level design file for its checks.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef LLC_VOLTAGE_COMPENSATOR_TOP_DEFINES_SVH
`define LLC_VOLTAGE_COMPENSATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LLCVC_CHECK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llcvc same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LLCVC_CHECK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llcvc next-cycle check failed");

`endif

[design/llcvc_pkg.sv]
`timescale 1ns / 1ps

package llcvc_pkg;

    // Feed-forward gain and control word limits.
    localparam int FF_MIN   = 0;
    localparam int FF_MAX   = 2047;
    localparam int CTRL_MIN = 2600;
    localparam int CTRL_MAX = 25000;

    // Fixed compensator output window, applied before the limits above.
    localparam int Y_LOW  = 2600;
    localparam int Y_HIGH = 25000;

    // Error rate limit and error clamp.
    localparam int ERR_JUMP  = 100;
    localparam int ERR_STEP  = 50;
    localparam int ERR_LIMIT = 100;

    localparam int DIV_STEPS = 16;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_ERR_COEF_NOW  = 3'd0;
    localparam logic [2:0] REG_ERR_COEF_PREV = 3'd1;
    localparam logic [2:0] REG_ERR_COEF_OLD  = 3'd2;
    localparam logic [2:0] REG_OUT_COEF_PREV = 3'd3;
    localparam logic [2:0] REG_OUT_COEF_OLD  = 3'd4;
    localparam logic [2:0] REG_FF_SCALE      = 3'd5;
    localparam logic [2:0] REG_FF_OFFSET     = 3'd6;
    localparam logic [2:0] REG_PERIOD_CLOCK  = 3'd7;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KFF,
        ST_A0,
        ST_A1,
        ST_B0,
        ST_B1,
        ST_B2,
        ST_GAIN,
        ST_LIMIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_EMIT
    } llcvc_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_KFF,
        OP_A0,
        OP_A1,
        OP_B0,
        OP_B1,
        OP_B2,
        OP_GAIN,
        OP_LIMIT,
        OP_DIV_INIT,
        OP_DIV,
        OP_EMIT
    } llcvc_op_t;

    typedef struct packed {
        llcvc_op_t op;
    } llcvc_cmd_t;

    typedef struct packed {
        logic out_free;
    } llcvc_status_t;

endpackage

[design/llc_voltage_compensator_top.sv]
`timescale 1ns / 1ps
// Voltage-loop compensator for a resonant converter.
// Input stream (s_axis_*): one request per control update carrying both
// ADC samples of the output voltage and the setpoint. Output stream
// (m_axis_*): one result per request with the control word, the period
// and duty register values and the four-point sample sum.
// Configuration channel (cfg_*): register index and data; it is always
// ready and should only be written while the block is idle.
// The work is set by one shared 32x17 multiplier used over seven steps
// and by a restoring divider that yields one quotient bit per cycle.
// One request is processed at a time.
// The output register frees the engine: a new request is accepted as
// soon as the previous one is finished, even if its result still waits
// to be taken. If the receiver stalls longer, the next result is held in
// the engine until the output register is free.
// Reset (rst_n low, asynchronous) clears the histories, restores the
// configuration defaults and drops all pending results.
`include "llc_voltage_compensator_top_defines.svh"

module llc_voltage_compensator_top
    import llcvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // sample_a[11:0], sample_b[23:12], target[39:24]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // control_word[14:0], period_value[30:15],
                                       // duty_value[45:31], sample_sum[59:46], zero fill
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    llcvc_cmd_t    cmd;
    llcvc_status_t status;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    llcvc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    llcvc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

    // The engine works on a single request: after acceptance it is busy.
    `LLCVC_CHECK_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // A result never leaves the control word limits.
    `LLCVC_CHECK_NOW(a_ctrl_in_range, m_axis_tvalid,
        (m_axis_tdata[14:0] >= 15'(CTRL_MIN)) && (m_axis_tdata[14:0] <= 15'(CTRL_MAX)))

    // The period value is the duty value less eight.
    `LLCVC_CHECK_NOW(a_period_duty, m_axis_tvalid,
        m_axis_tdata[30:15] == ({1'b0, m_axis_tdata[45:31]} - 16'd8))

    // A result is only loaded when the output register is free.
    `LLCVC_CHECK_NOW(a_no_overwrite, cmd.op == OP_EMIT, !m_axis_tvalid || m_axis_tready)

endmodule

[design/llcvc_ctrl.sv]
`timescale 1ns / 1ps

module llcvc_ctrl
    import llcvc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  llcvc_status_t status,
    output llcvc_cmd_t    cmd
);

    llcvc_state_t state_reg, state_next;
    logic [3:0]   div_cnt_reg, div_cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_KFF;
                end
            end
            ST_KFF:      state_next = ST_A0;
            ST_A0:       state_next = ST_A1;
            ST_A1:       state_next = ST_B0;
            ST_B0:       state_next = ST_B1;
            ST_B1:       state_next = ST_B2;
            ST_B2:       state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_LIMIT;
            ST_LIMIT:    state_next = ST_DIV_INIT;
            ST_DIV_INIT:
            begin
                state_next   = ST_DIV;
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'(DIV_STEPS - 1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = OP_NONE;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = OP_LOAD;
                end
            end
            ST_KFF:      cmd.op = OP_KFF;
            ST_A0:       cmd.op = OP_A0;
            ST_A1:       cmd.op = OP_A1;
            ST_B0:       cmd.op = OP_B0;
            ST_B1:       cmd.op = OP_B1;
            ST_B2:       cmd.op = OP_B2;
            ST_GAIN:     cmd.op = OP_GAIN;
            ST_LIMIT:    cmd.op = OP_LIMIT;
            ST_DIV_INIT: cmd.op = OP_DIV_INIT;
            ST_DIV:      cmd.op = OP_DIV;
            ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.op = OP_EMIT;
                end
            end
            default:     cmd.op = OP_NONE;
        endcase
    end

endmodule

[design/llcvc_datapath.sv]
`timescale 1ns / 1ps

module llcvc_datapath
    import llcvc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  llcvc_cmd_t    cmd,
    output llcvc_status_t status,
    input  logic [39:0]   in_data,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [30:0]   cfg_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_data
);

    // Configuration registers.
    logic signed [15:0] coef_now_reg, coef_prev_reg, coef_old_reg;
    logic signed [15:0] ocoef_prev_reg, ocoef_old_reg;
    logic        [14:0] ff_scale_reg;
    logic signed [15:0] ff_offset_reg;
    logic        [30:0] period_clock_reg;

    // Loop state.
    logic signed [7:0]  err_last_reg, err_older_reg;
    logic signed [15:0] out_last_reg, out_older_reg;
    logic        [14:0] ctrl_last_reg;
    logic        [11:0] prev_a_reg, prev_b_reg;

    // Per-item working registers.
    logic signed [7:0]  err_reg;
    logic        [13:0] sum_reg;
    logic        [10:0] kff_reg;
    logic signed [31:0] acc_reg, acca_reg;
    logic        [14:0] y_reg, u_reg;
    logic        [14:0] rem_reg;
    logic        [15:0] quo_reg;
    logic               ovf_reg;

    // Result register.
    logic               out_valid_reg;
    logic        [14:0] out_ctrl_reg;
    logic        [15:0] out_period_reg;
    logic        [14:0] out_duty_reg;
    logic        [13:0] out_sum_reg;

    // Input decode and error shaping.
    logic        [11:0] smp_a, smp_b;
    logic signed [15:0] target;
    logic        [13:0] fb;
    logic signed [17:0] err_full, err_delta, err_lim;
    logic signed [7:0]  err_clamped;
    logic        [13:0] sum_full;

    assign smp_a  = in_data[11:0];
    assign smp_b  = in_data[23:12];
    assign target = $signed(in_data[39:24]);
    assign fb     = {(13'(smp_a) + 13'(smp_b)), 1'b0};
    assign sum_full = 14'(smp_a) + 14'(smp_b) + 14'(prev_a_reg) + 14'(prev_b_reg);

    always_comb
    begin
        err_full  = 18'(target) - $signed({4'b0, fb});
        err_delta = err_full - 18'(err_last_reg);
        if (err_delta > 18'(ERR_JUMP))
        begin
            err_lim = 18'(err_last_reg) + 18'(ERR_STEP);
        end
        else if (err_delta < -18'(ERR_JUMP))
        begin
            err_lim = 18'(err_last_reg) - 18'(ERR_STEP);
        end
        else
        begin
            err_lim = err_full;
        end
        if (err_lim > 18'(ERR_LIMIT))
        begin
            err_clamped = 8'(ERR_LIMIT);
        end
        else if (err_lim < -18'(ERR_LIMIT))
        begin
            err_clamped = -8'(ERR_LIMIT);
        end
        else
        begin
            err_clamped = err_lim[7:0];
        end
    end

    // Shared multiplier; only the low 32 bits of each product are kept.
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic signed [31:0] mul_lo;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_KFF:
            begin
                mul_a = $signed({17'b0, ctrl_last_reg});
                mul_b = $signed({2'b0, ff_scale_reg});
            end
            OP_A0:
            begin
                mul_a = 32'(ocoef_prev_reg);
                mul_b = 17'(out_last_reg);
            end
            OP_A1:
            begin
                mul_a = 32'(ocoef_old_reg);
                mul_b = 17'(out_older_reg);
            end
            OP_B0:
            begin
                mul_a = 32'(coef_now_reg);
                mul_b = 17'(err_reg);
            end
            OP_B1:
            begin
                mul_a = 32'(coef_prev_reg);
                mul_b = 17'(err_last_reg);
            end
            OP_B2:
            begin
                mul_a = 32'(coef_old_reg);
                mul_b = 17'(err_older_reg);
            end
            OP_GAIN:
            begin
                mul_a = acc_reg;
                mul_b = $signed({6'b0, kff_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p  = 49'(mul_a) * 49'(mul_b);
    assign mul_lo = mul_p[31:0];

    // Feed-forward gain from the previous control word.
    logic signed [17:0] kff_raw;
    logic        [10:0] kff_clamped;

    always_comb
    begin
        kff_raw = $signed({3'b0, mul_p[29:15]}) - 18'(ff_offset_reg);
        if (kff_raw < 18'(FF_MIN))
        begin
            kff_clamped = 11'(FF_MIN);
        end
        else if (kff_raw > 18'(FF_MAX))
        begin
            kff_clamped = 11'(FF_MAX);
        end
        else
        begin
            kff_clamped = kff_raw[10:0];
        end
    end

    // Output scaling and limits.
    logic signed [31:0] comp_sum;
    logic signed [18:0] y_full;
    logic        [14:0] y_clamped, u_lo, u_clamped;

    always_comb
    begin
        comp_sum = (acc_reg >>> 7) + acca_reg;
        y_full   = comp_sum[31:13];
        if (y_full < 19'(Y_LOW))
        begin
            y_clamped = 15'(Y_LOW);
        end
        else if (y_full > 19'(Y_HIGH))
        begin
            y_clamped = 15'(Y_HIGH);
        end
        else
        begin
            y_clamped = y_full[14:0];
        end
        u_lo      = (y_clamped < 15'(CTRL_MIN)) ? 15'(CTRL_MIN) : y_clamped;
        u_clamped = (u_lo > 15'(CTRL_MAX)) ? 15'(CTRL_MAX) : u_lo;
    end

    // Restoring divider step, one quotient bit per cycle.
    logic [15:0] trial;
    logic        trial_ok;
    logic [15:0] trial_diff;

    assign trial      = {rem_reg, quo_reg[15]};
    assign trial_ok   = (trial >= {1'b0, u_reg});
    assign trial_diff = trial - {1'b0, u_reg};

    logic [15:0] quotient;
    logic [14:0] half;

    assign quotient = ovf_reg ? 16'hFFFF : quo_reg;
    assign half     = quotient[15:1];

    assign status.out_free = !out_valid_reg || out_ready;

    // Configuration and loop state, reset to their defined values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_now_reg     <= '0;
            coef_prev_reg    <= '0;
            coef_old_reg     <= '0;
            ocoef_prev_reg   <= '0;
            ocoef_old_reg    <= '0;
            ff_scale_reg     <= 15'd32767;
            ff_offset_reg    <= '0;
            period_clock_reg <= 31'd1000000;
            err_last_reg     <= '0;
            err_older_reg    <= '0;
            out_last_reg     <= '0;
            out_older_reg    <= '0;
            ctrl_last_reg    <= '0;
            prev_a_reg       <= '0;
            prev_b_reg       <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ERR_COEF_NOW:  coef_now_reg     <= $signed(cfg_data[15:0]);
                    REG_ERR_COEF_PREV: coef_prev_reg    <= $signed(cfg_data[15:0]);
                    REG_ERR_COEF_OLD:  coef_old_reg     <= $signed(cfg_data[15:0]);
                    REG_OUT_COEF_PREV: ocoef_prev_reg   <= $signed(cfg_data[15:0]);
                    REG_OUT_COEF_OLD:  ocoef_old_reg    <= $signed(cfg_data[15:0]);
                    REG_FF_SCALE:      ff_scale_reg     <= cfg_data[14:0];
                    REG_FF_OFFSET:     ff_offset_reg    <= $signed(cfg_data[15:0]);
                    REG_PERIOD_CLOCK:  period_clock_reg <= cfg_data;
                    default:           period_clock_reg <= period_clock_reg;
                endcase
            end
            if (cmd.op == OP_LOAD)
            begin
                prev_a_reg <= smp_a;
                prev_b_reg <= smp_b;
            end
            if (cmd.op == OP_EMIT)
            begin
                err_older_reg <= err_last_reg;
                err_last_reg  <= err_reg;
                out_older_reg <= out_last_reg;
                out_last_reg  <= $signed({1'b0, y_reg});
                ctrl_last_reg <= u_reg;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and result registers.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                err_reg <= err_clamped;
                sum_reg <= sum_full;
            end
            OP_KFF:      kff_reg  <= kff_clamped;
            OP_A0:       acca_reg <= mul_lo;
            OP_A1:       acca_reg <= acca_reg + mul_lo;
            OP_B0:       acc_reg  <= mul_lo;
            OP_B1:       acc_reg  <= acc_reg + mul_lo;
            OP_B2:       acc_reg  <= acc_reg + mul_lo;
            OP_GAIN:     acc_reg  <= mul_lo;
            OP_LIMIT:
            begin
                y_reg <= y_clamped;
                u_reg <= u_clamped;
            end
            OP_DIV_INIT:
            begin
                ovf_reg <= (period_clock_reg[30:16] >= u_reg);
                rem_reg <= period_clock_reg[30:16];
                quo_reg <= period_clock_reg[15:0];
            end
            OP_DIV:
            begin
                rem_reg <= trial_ok ? trial_diff[14:0] : trial[14:0];
                quo_reg <= {quo_reg[14:0], trial_ok};
            end
            OP_EMIT:
            begin
                out_ctrl_reg   <= u_reg;
                out_period_reg <= {1'b0, half} - 16'd8;
                out_duty_reg   <= half;
                out_sum_reg    <= sum_reg;
            end
            default:
            begin
                kff_reg <= kff_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {4'b0, out_sum_reg, out_duty_reg, out_period_reg, out_ctrl_reg};

endmodule

[verif/llcvc_checker.sv]
`timescale 1ns / 1ps

// Watches the three channels of the compensator. It keeps its own copy of the
// loop state and the registers, predicts one result per accepted request and
// compares every accepted result with the oldest prediction still waiting.
module llcvc_checker
    import llcvc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [30:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    // Laid out so that a cast of the low 60 bits of m_axis_tdata fills it.
    typedef struct packed {
        logic [13:0]        sample_sum;
        logic [14:0]        duty_value;
        logic signed [15:0] period_value;
        logic [14:0]        control_word;
    } loop_result_t;

    logic signed [15:0] gain_err_now, gain_err_prev, gain_err_old;
    logic signed [15:0] gain_out_prev, gain_out_old;
    logic [14:0]        ff_scale;
    logic signed [15:0] ff_offset;
    logic [30:0]        period_clock;

    logic signed [7:0]  err_last, err_older;
    logic signed [15:0] out_last, out_older;
    logic [15:0]        ctrl_last;
    logic [11:0]        prev_a, prev_b;

    loop_result_t expected_updates[$];
    loop_result_t got, want;

    // One control update: works out the result and moves the histories on.
    function automatic loop_result_t advance_loop(logic [11:0] a, logic [11:0] b,
                                                  logic signed [15:0] target);
        longint       scaled;
        int           kff, fb, err, jump, acc_out, acc_err, y, word;
        logic [31:0]  divisor, quot;
        logic [15:0]  half;
        loop_result_t res;

        scaled = (longint'(ctrl_last) * longint'(ff_scale)) >>> 15;
        kff = int'(scaled) - int'(ff_offset);
        if (kff < FF_MIN) kff = FF_MIN;
        if (kff > FF_MAX) kff = FF_MAX;

        fb = 2 * (int'(a) + int'(b));
        err = int'(target) - fb;
        jump = err - int'(err_last);
        if (jump > ERR_JUMP)
            err = int'(err_last) + ERR_STEP;
        else if (jump < -ERR_JUMP)
            err = int'(err_last) - ERR_STEP;
        if (err > ERR_LIMIT) err = ERR_LIMIT;
        if (err < -ERR_LIMIT) err = -ERR_LIMIT;

        // 32-bit products and sums wrap, as in the block.
        acc_out = int'(gain_out_prev) * int'(out_last) + int'(gain_out_old) * int'(out_older);
        acc_err = int'(gain_err_now) * err + int'(gain_err_prev) * int'(err_last)
                + int'(gain_err_old) * int'(err_older);
        y = (((acc_err * kff) >>> 7) + acc_out) >>> 13;
        if (y < Y_LOW) y = Y_LOW;
        if (y > Y_HIGH) y = Y_HIGH;

        word = y;
        if (word < CTRL_MIN) word = CTRL_MIN;
        if (word > CTRL_MAX) word = CTRL_MAX;

        if (word <= 0)
            quot = 32'd65535;
        else
        begin
            divisor = word;
            quot = {1'b0, period_clock} / divisor;
            if (quot > 32'd65535) quot = 32'd65535;
        end
        half = quot[16:1];

        res.control_word = word[14:0];
        res.period_value = half - 16'd8;
        res.duty_value   = half[14:0];
        res.sample_sum   = 14'(a) + 14'(b) + 14'(prev_a) + 14'(prev_b);

        prev_a    = a;
        prev_b    = b;
        err_older = err_last;
        err_last  = err[7:0];
        out_older = out_last;
        out_last  = y[15:0];
        ctrl_last = word[15:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_err_now  <= '0;
            gain_err_prev <= '0;
            gain_err_old  <= '0;
            gain_out_prev <= '0;
            gain_out_old  <= '0;
            ff_scale      <= 15'd32767;
            ff_offset     <= '0;
            period_clock  <= 31'd1000000;
            err_last      = '0;
            err_older     = '0;
            out_last      = '0;
            out_older     = '0;
            ctrl_last     = '0;
            prev_a        = '0;
            prev_b        = '0;
            expected_updates.delete();
            fail_count    <= 0;
            pending       <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ERR_COEF_NOW:  gain_err_now  <= cfg_data[15:0];
                    REG_ERR_COEF_PREV: gain_err_prev <= cfg_data[15:0];
                    REG_ERR_COEF_OLD:  gain_err_old  <= cfg_data[15:0];
                    REG_OUT_COEF_PREV: gain_out_prev <= cfg_data[15:0];
                    REG_OUT_COEF_OLD:  gain_out_old  <= cfg_data[15:0];
                    REG_FF_SCALE:      ff_scale      <= cfg_data[14:0];
                    REG_FF_OFFSET:     ff_offset     <= cfg_data[15:0];
                    REG_PERIOD_CLOCK:  period_clock  <= cfg_data;
                    default: ;
                endcase
            end

            // Results are compared before the request of the same edge is
            // predicted, so a stray result cannot match a fresh prediction.
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[59:0];
                if (expected_updates.size() == 0)
                begin
                    $error("result 0x%h arrived with no request outstanding", got);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (got != want)
                        fail_count <= fail_count + 1;
                    if (got.control_word != want.control_word)
                        $error("control_word: expected %0d, actual %0d",
                               want.control_word, got.control_word);
                    if (got.period_value != want.period_value)
                        $error("period_value: expected %0d, actual %0d",
                               $signed(want.period_value), $signed(got.period_value));
                    if (got.duty_value != want.duty_value)
                        $error("duty_value: expected %0d, actual %0d",
                               want.duty_value, got.duty_value);
                    if (got.sample_sum != want.sample_sum)
                        $error("sample_sum: expected %0d, actual %0d",
                               want.sample_sum, got.sample_sum);
                end
            end

            if (s_axis_tvalid && s_axis_tready)
                expected_updates.push_back(advance_loop(s_axis_tdata[11:0],
                                                        s_axis_tdata[23:12],
                                                        s_axis_tdata[39:24]));

            pending <= expected_updates.size();
        end
    end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

// Top of the compensator testbench. Besides a watchdog and the verdict, it
// only makes stimulus: requests on the input stream, register writes between
// phases and back-pressure on the output stream. All prediction and comparison
// is done by the checker instance beside the block, which hands back a failure
// count and the number of results still owed.
module tb_top;
    import llcvc_pkg::*;

    // Longest run of cycles without any handshake that a correct block can
    // show is the long receiver hold-off plus a latency; this is many times it.
    localparam int IDLE_LIMIT   = 4000;
    // The receiver holds off once, for this long, once this many requests
    // have gone in, so that the block fills up and refuses further requests.
    localparam int HOLD_AT      = 500;
    localparam int HOLD_CYCLES  = 400;
    // Settling time after the last result, a little over the block latency.
    localparam int SETTLE       = 40;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 150;

    // Register settings applied at the start of each random phase.
    typedef enum int { SET_TOP, SET_BOTTOM, SET_TYPICAL, SET_WILD } setting_kind_t;
    // Back-pressure patterns of the receiver.
    typedef enum int { RX_STEADY, RX_COIN, RX_SPARSE, RX_BURSTY } stall_kind_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // sample_a[11:0], sample_b[23:12], target[39:24]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // control_word[14:0], period_value[30:15],
                                 // duty_value[45:31], sample_sum[59:46], zero fill
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [30:0] cfg_data;

    int fail_count;
    int pending;
    int in_count;
    int burst_left;
    int idle_cycles;

    llc_voltage_compensator_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    llcvc_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    // 10 ns clock, high then low.
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // All inputs change at the falling edge, so the block and the checker
    // both see settled values at the rising edge.

    // One register write; the channel is normally always ready, but the
    // handshake is still honoured.
    task automatic write_reg(input logic [2:0] index, input logic [30:0] data);
        begin
            cfg_index = index;
            cfg_data  = data;
            cfg_valid = 1'b1;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            @(negedge clk);
            cfg_valid = 1'b0;
        end
    endtask

    // Writes every register. Signed coefficients go over as their low 16 bits.
    task automatic apply_settings(input int c_now, input int c_prev, input int c_old,
                                  input int o_prev, input int o_old, input int scale,
                                  input int offset, input int clock_div);
        begin
            write_reg(REG_ERR_COEF_NOW,  {15'd0, 16'(c_now)});
            write_reg(REG_ERR_COEF_PREV, {15'd0, 16'(c_prev)});
            write_reg(REG_ERR_COEF_OLD,  {15'd0, 16'(c_old)});
            write_reg(REG_OUT_COEF_PREV, {15'd0, 16'(o_prev)});
            write_reg(REG_OUT_COEF_OLD,  {15'd0, 16'(o_old)});
            write_reg(REG_FF_SCALE,      {16'd0, 15'(scale)});
            write_reg(REG_FF_OFFSET,     {15'd0, 16'(offset)});
            write_reg(REG_PERIOD_CLOCK,  31'(clock_div));
        end
    endtask

    // Offers one request and returns at the falling edge after it is taken.
    // The sender works in bursts: when a burst runs out, tvalid drops for a
    // random gap before the next one; some bursts are long enough to give
    // stretches with no gaps at all.
    task automatic send_request(input logic [11:0] a, input logic [11:0] b,
                                input logic [15:0] target);
        begin
            if (burst_left == 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
            end
            s_axis_tdata  = {target, b, a};
            s_axis_tvalid = 1'b1;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            in_count++;
            burst_left--;
            @(negedge clk);
        end
    endtask

    // Mostly well-formed requests: the setpoint sits close to the feedback so
    // the error wanders inside and just outside the rate limit. The rest are
    // fully random fields and corner values.
    task automatic send_random;
        int          pick;
        logic [11:0] a, b;
        logic [15:0] target;
        begin
            pick = $urandom_range(0, 9);
            a = 12'($urandom_range(0, 4095));
            b = 12'($urandom_range(0, 4095));
            if (pick < 7)
                target = 16'(2 * (int'(a) + int'(b)) + int'($urandom_range(0, 300)) - 150);
            else if (pick < 9)
                target = 16'($urandom);
            else
            begin
                a = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                b = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                target = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            end
            send_request(a, b, target);
        end
    endtask

    // Waits until every result has come back, then lets the block settle
    // before any register is touched.
    task automatic wait_idle;
        begin
            s_axis_tvalid = 1'b0;
            while (pending != 0)
                @(negedge clk);
            repeat (SETTLE) @(negedge clk);
        end
    endtask

    // Short directed sequence: sample and setpoint extremes, the error far
    // outside 16 bits, rate limiting in both directions and just inside it,
    // the error clamp, alternating bit patterns and the largest sample sum.
    task automatic run_directed;
        int dir_a [22] = '{0, 4095, 4095, 0, 0, 4095, 0, 1000, 1000, 1000,
                           1000, 500, 500, 500, 500, 500, 2730, 1365, 2730,
                           4095, 2048, 2047};
        int dir_b [22] = '{0, 4095, 4095, 0, 0, 0, 4095, 1000, 1000, 1000,
                           1000, 500, 500, 500, 500, 500, 1365, 2730, 2730,
                           4095, 2047, 2048};
        int dir_t [22] = '{0, 32767, -32768, -32768, 32767, 8190, 8190, 4000,
                           4100, 4101, 3899, 2000, 2101, 2150, 1900, 1999,
                           21845, -21846, 10920, 16380, 8190, 8290};
        begin
            for (int i = 0; i < 22; i++)
                send_request(12'(dir_a[i]), 12'(dir_b[i]), 16'(dir_t[i]));
        end
    endtask

    // Stimulus and verdict.
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_ERR_COEF_NOW;
        cfg_data      = '0;
        in_count      = 0;
        burst_left    = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // A plausible loop: the output term nearly integrates, the error
        // terms give the zeros.
        apply_settings(3000, -2000, 500, 8192, 0, 32767, 0, 1000000);
        run_directed();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_idle();
            case (phase < 2 ? setting_kind_t'(phase) : setting_kind_t'(2 + phase % 2))
                SET_TOP:
                    apply_settings(32767, 32767, 32767, 32767, 32767, 32767, -32768,
                                   2147483647);
                SET_BOTTOM:
                    apply_settings(-32768, -32768, -32768, -32768, -32768, 0, 32767, 1);
                SET_TYPICAL:
                    apply_settings($urandom_range(1000, 8000), -$urandom_range(0, 6000),
                                   $urandom_range(0, 3000), $urandom_range(6000, 10000),
                                   $urandom_range(0, 4000) - 2000, $urandom_range(0, 32767),
                                   $urandom_range(0, 1500) - 1000,
                                   $urandom_range(100000, 200000000));
                default:
                    apply_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                                   $urandom_range(0, 65535), $urandom_range(0, 32767),
                                   $urandom_range(0, 65535),
                                   $urandom_range(1, 2147483647));
            endcase
            repeat (PHASE_ITEMS) send_random();
        end

        wait_idle();
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver: changes its stall pattern after each run of random length, from
    // always ready to sparse acceptance, and once holds off for a long
    // stretch while the sender keeps offering requests.
    initial
    begin : receiver
        stall_kind_t pattern;
        int          left;
        bit          held;
        m_axis_tready = 1'b0;
        pattern = RX_STEADY;
        left = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && in_count >= HOLD_AT)
            begin
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (left == 0)
            begin
                pattern = stall_kind_t'($urandom_range(0, 3));
                left = $urandom_range(20, 80);
            end
            left--;
            case (pattern)
                RX_STEADY: m_axis_tready = 1'b1;
                RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                default:   m_axis_tready = ((left % 16) < 4);
            endcase
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule
